// File: rtl/core/assert_macros.svh
// Assertion macros for the timer queue RTL, included by stq_datapath.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("timer queue assertion failed");
`define STQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("timer queue assertion failed");
`else
`define STQ_ASSERT(label, clk, rstn, prop)
`define STQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/stq_pkg.sv
// Package for the sorted timer queue: sizes, event and action codes,
// and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none
package stq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int DELAY_BITS  = 32;
    localparam int TIME_BITS   = 64;
    localparam int EV_BITS     = 2;

    localparam logic [EV_BITS-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_BITS-1:0] EV_ADDED   = 2'd1;
    localparam logic [EV_BITS-1:0] EV_FULL    = 2'd2;
    localparam logic [EV_BITS-1:0] EV_EXPIRED = 2'd3;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic calc_add;
        logic calc_tick;
        logic insert;
        logic refuse;
        logic pop;
        logic report;
    } stq_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic full;
    } stq_status_t;
endpackage
`default_nettype wire

// File: rtl/core/stq_ctrl.sv
// Sequencer of the timer queue: load, compute, update the queue, report.
// Depends on stq_pkg for the command and status structs.
`default_nettype none
module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire stq_status_t status,
    output stq_cmd_t         cmd
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc_add  = !status.is_tick;
                cmd.calc_tick = status.is_tick;
                state_next    = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.insert = !status.is_tick && !status.full;
                cmd.refuse = !status.is_tick && status.full;
                cmd.pop    = status.is_tick;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (out_free) begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || cmd.report;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/stq_datapath.sv
// Datapath of the timer queue: time counter, sorted compare-and-shift entry
// array, event registers and the output word register. Depends on stq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module stq_datapath
    import stq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stq_cmd_t              cmd,
    output stq_status_t                status,
    input  wire logic                  s_action,
    input  wire logic [DELAY_BITS-1:0] s_delay,
    input  wire logic [TAG_BITS-1:0]   s_tag,
    output logic [EV_BITS-1:0]         m_event_res,
    output logic [TAG_BITS-1:0]        m_expired_tag,
    output logic                       m_head_changed,
    output logic [TIME_BITS-1:0]       m_reload_delay,
    output logic                       m_timer_enabled,
    output logic [COUNT_BITS-1:0]      m_pending_count
);
    logic                  action_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [TAG_BITS-1:0]   tag_in_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TIME_BITS-1:0]  when_reg;
    logic [TIME_BITS-1:0]  exp_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_reg [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0] count_reg;
    logic [EV_BITS-1:0]    ev_reg;
    logic [TAG_BITS-1:0]   etag_reg;
    logic                  chg_reg;

    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] at_end;
    logic                   is_empty;
    logic                   due;
    logic                   head_ahead;
    logic [TIME_BITS-1:0]   reload;

    assign is_empty      = (count_reg == '0);
    assign status.is_tick = (action_reg == ACT_TICK);
    assign status.full    = (count_reg == COUNT_BITS'(QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i]     = (COUNT_BITS'(i) < count_reg) && (exp_reg[i] > when_reg);
            at_end[i] = (COUNT_BITS'(i) == count_reg);
        end
    end

    assign due        = !is_empty && (exp_reg[0] <= now_reg);
    assign head_ahead = !is_empty && (exp_reg[0] > now_reg);
    assign reload     = head_ahead ? (exp_reg[0] - now_reg) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            delay_reg  <= s_delay;
            tag_in_reg <= s_tag;
        end
        if (cmd.calc_add) begin
            when_reg <= now_reg + TIME_BITS'(delay_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.calc_tick) begin
                now_reg <= now_reg + TIME_BITS'(1);
            end
            if (cmd.insert) begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end else if (cmd.pop && due) begin
                count_reg <= count_reg - COUNT_BITS'(1);
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
        logic shift_up;
        logic place;
        if (g == 0) begin : g_first
            assign shift_up = 1'b0;
        end else begin : g_rest
            assign shift_up = gt[g-1];
        end
        assign place = !shift_up && (gt[g] || at_end[g]);

        always_ff @(posedge aclk) begin
            if (cmd.insert) begin
                if (shift_up) begin
                    if (g > 0) begin
                        exp_reg[g] <= exp_reg[(g > 0) ? g - 1 : 0];
                        tag_reg[g] <= tag_reg[(g > 0) ? g - 1 : 0];
                    end
                end else if (place) begin
                    exp_reg[g] <= when_reg;
                    tag_reg[g] <= tag_in_reg;
                end
            end else if (cmd.pop && due && (g < QUEUE_DEPTH - 1)) begin
                exp_reg[g] <= exp_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                tag_reg[g] <= tag_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            ev_reg   <= EV_ADDED;
            etag_reg <= '0;
            chg_reg  <= gt[0] || is_empty;
        end else if (cmd.refuse) begin
            ev_reg   <= EV_FULL;
            etag_reg <= '0;
            chg_reg  <= 1'b0;
        end else if (cmd.pop) begin
            ev_reg   <= due ? EV_EXPIRED : EV_NONE;
            etag_reg <= due ? tag_reg[0] : '0;
            chg_reg  <= due;
        end
        if (cmd.report) begin
            m_event_res     <= ev_reg;
            m_expired_tag   <= etag_reg;
            m_head_changed  <= chg_reg;
            m_reload_delay  <= reload;
            m_timer_enabled <= !is_empty;
            m_pending_count <= count_reg;
        end
    end

    `STQ_ASSERT(a_count_range, aclk, aresetn, count_reg <= COUNT_BITS'(QUEUE_DEPTH))
    `STQ_ASSERT(a_insert_grows, aclk, aresetn, cmd.insert |=> count_reg == $past(count_reg) + 1'b1)
    `STQ_ASSERT(a_pop_shrinks, aclk, aresetn, (cmd.pop && due) |=> count_reg == $past(count_reg) - 1'b1)
    `STQ_ASSERT(a_tick_advances, aclk, aresetn, cmd.calc_tick |=> now_reg == $past(now_reg) + 1'b1)
    `STQ_ASSERT(a_head_sorted, aclk, aresetn, (count_reg >= COUNT_BITS'(2)) |-> exp_reg[0] <= exp_reg[1])
endmodule
`default_nettype wire

// File: rtl/core/sorted_timer_queue.sv
// Sorted timer queue: holds up to QUEUE_DEPTH pending timers in expiry order.
// Input word: s_action (0 add, 1 tick), s_delay (ticks from now), s_tag.
// Every accepted word yields exactly one result word on the m_ channel:
// event (none, added, refused because full, expired), the expired tag,
// whether the head changed, the reload delay for the head, the timer enable
// and the number of pending timers.
// An add stores now plus delay behind all entries with an equal or earlier
// expiry time; a tick advances the time counter and then pops the head if
// it is due. At most one timer expires per tick.
// The sequencer runs load, compute, queue update and report in turn and
// loads the result into the output register in the report step; it takes
// no new word while one is still in those steps.
// The result sits in an output register; s_ready returns as soon as the
// result is loaded, so the next word may be taken while the result waits.
// If m_ready stays low, the following result holds in the report step and
// s_ready stays low until the output register frees.
// Reset (aresetn low at a clock edge) clears the time counter, the pending
// count and both channel handshakes; entry contents need no clearing.
// Depends on stq_pkg, stq_ctrl and stq_datapath.
`default_nettype none
module sorted_timer_queue
    import stq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [DELAY_BITS-1:0] s_delay,
    input  wire logic [TAG_BITS-1:0]   s_tag,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [EV_BITS-1:0]         m_event_res,
    output logic [TAG_BITS-1:0]        m_expired_tag,
    output logic                       m_head_changed,
    output logic [TIME_BITS-1:0]       m_reload_delay,
    output logic                       m_timer_enabled,
    output logic [COUNT_BITS-1:0]      m_pending_count
);
    stq_cmd_t    cmd;
    stq_status_t status;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_action        (s_action),
        .s_delay         (s_delay),
        .s_tag           (s_tag),
        .m_event_res     (m_event_res),
        .m_expired_tag   (m_expired_tag),
        .m_head_changed  (m_head_changed),
        .m_reload_delay  (m_reload_delay),
        .m_timer_enabled (m_timer_enabled),
        .m_pending_count (m_pending_count)
    );
endmodule
`default_nettype wire
